// File: src/bodlm_pkg.sv
// Shared types, constants and the dither threshold function for the
// bilinear ordered-dither layer mask. No dependencies.
`timescale 1ns / 1ps

package bodlm_pkg;

   localparam int MAX_LAYERS = 4;
   localparam int LAYERS_DEF = 4;
   localparam int DITHER_DIM = 16;
   localparam int DIM_BITS   = $clog2(DITHER_DIM);

   localparam logic [7:0] GRID_SIZE_RESET = 8'd10;

   // Bilinear numerator over 17: up to 15 * 255^2, and the scaled compare terms.
   localparam int NSUM_W = 20;
   localparam int CMP_W  = 26;

   localparam logic [3:0] MAGIC4 [4][4] = '{
      '{4'd0,  4'd14, 4'd3,  4'd13},
      '{4'd11, 4'd5,  4'd8,  4'd6},
      '{4'd12, 4'd2,  4'd15, 4'd1},
      '{4'd7,  4'd9,  4'd4,  4'd10}
   };

   typedef struct packed {
      logic [7:0]  grid_x;
      logic [7:0]  grid_z;
      logic [3:0]  shift_x;
      logic [3:0]  shift_z;
      logic [15:0] layer0_alpha;
      logic [15:0] layer1_alpha;
      logic [15:0] layer2_alpha;
      logic [15:0] layer3_alpha;
      logic [3:0]  layer_used;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] selected_mask;
      logic [2:0] selected_count;
   } rsp_payload_type;

   // Bilinear corner weights: w00 = (s-x)(s-z), w10 = x(s-z), w01 = (s-x)z, w11 = xz.
   typedef struct packed {
      logic [15:0] w00;
      logic [15:0] w10;
      logic [15:0] w01;
      logic [15:0] w11;
   } weights_type;

   // Per-stage load enables of the pipeline.
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } pipe_ctl_type;

   // Two-level expanded magic matrix, rescaled from 0..255 to 0..253 with rounding.
   function automatic logic [7:0] dither_threshold(input logic [DIM_BITS-1:0] col,
                                                   input logic [DIM_BITS-1:0] row);
      logic [7:0]  v;
      logic [14:0] t;
      v = {MAGIC4[col[1:0]][row[1:0]], 4'b0000} + 8'(MAGIC4[col[3:2]][row[3:2]]);
      t = 15'd64 + 15'd127 * 15'(v);
      return t[14:7];
   endfunction

endpackage

// File: src/bodlm_prep.sv
// Shared front end: clamps the point, forms the bilinear weights, the dither
// threshold and the scaled threshold term. Depends on bodlm_pkg.
`timescale 1ns / 1ps

module bodlm_prep
   import bodlm_pkg::*;
(
   input  logic            clock,
   input  pipe_ctl_type    ctl,
   input  logic [7:0]      grid_size,
   input  req_payload_type req_data,
   output weights_type     weights,
   output logic [15:0]     s2_out,
   output logic [CMP_W-1:0] rhs_out,
   output logic [3:0]      used_out
);

   logic [7:0]  s_eff;
   logic [7:0]  s_max;
   logic [7:0]  x_c;
   logic [7:0]  z_c;
   logic [7:0]  ix;
   logic [7:0]  iz;
   logic [DIM_BITS-1:0] col;
   logic [DIM_BITS-1:0] row;

   weights_type      w_ff, w_in;
   logic [7:0]       thr_ff, thr_in;
   logic [15:0]      s2a_ff, s2a_in;
   logic [3:0]       used1_ff;
   logic [15:0]      s2b_ff;
   logic [CMP_W-1:0] rhs_ff, rhs_in;
   logic [3:0]       used2_ff;

   always_comb begin
      s_eff = (grid_size == 8'd0) ? 8'd1 : grid_size;
      s_max = s_eff - 8'd1;
      x_c   = (req_data.grid_x > s_max) ? s_max : req_data.grid_x;
      z_c   = (req_data.grid_z > s_max) ? s_max : req_data.grid_z;
      ix    = s_eff - x_c;
      iz    = s_eff - z_c;
      col   = x_c[DIM_BITS-1:0] + req_data.shift_x;
      row   = z_c[DIM_BITS-1:0] + req_data.shift_z;
      w_in.w00 = ix * iz;
      w_in.w10 = x_c * iz;
      w_in.w01 = ix * z_c;
      w_in.w11 = x_c * z_c;
      thr_in   = dither_threshold(col, row);
      s2a_in   = s_eff * s_eff;
      // c > T  <=>  34*nsum + s^2 >= 2*(T+1)*s^2
      rhs_in   = CMP_W'({(9'({1'b0, thr_ff}) + 9'd1) * 25'(s2a_ff), 1'b0});
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         w_ff     <= w_in;
         thr_ff   <= thr_in;
         s2a_ff   <= s2a_in;
         used1_ff <= req_data.layer_used;
      end
      if (ctl.en2) begin
         s2b_ff   <= s2a_ff;
         rhs_ff   <= rhs_in;
         used2_ff <= used1_ff;
      end
   end

   assign weights  = w_ff;
   assign s2_out   = s2b_ff;
   assign rhs_out  = rhs_ff;
   assign used_out = used2_ff;

endmodule

// File: src/bodlm_lane.sv
// One layer lane: weighted corner sum of the layer's four densities and the
// threshold compare. Depends on bodlm_pkg.
`timescale 1ns / 1ps

module bodlm_lane
   import bodlm_pkg::*;
(
   input  logic             clock,
   input  pipe_ctl_type     ctl,
   input  logic [15:0]      alpha,
   input  weights_type      weights,
   input  logic [15:0]      s2,
   input  logic [CMP_W-1:0] rhs,
   output logic             hit
);

   logic [15:0]       alpha_ff;
   logic [NSUM_W-1:0] nsum_ff, nsum_in;
   logic [CMP_W-1:0]  lhs;

   // The factor 17 of the densities is folded into the compare as 34 = 32 + 2.
   always_comb begin
      nsum_in = NSUM_W'(alpha_ff[3:0]   * weights.w00)
              + NSUM_W'(alpha_ff[7:4]   * weights.w10)
              + NSUM_W'(alpha_ff[11:8]  * weights.w01)
              + NSUM_W'(alpha_ff[15:12] * weights.w11);
      lhs = CMP_W'({nsum_ff, 5'b00000}) + CMP_W'({nsum_ff, 1'b0}) + CMP_W'(s2);
      hit = (lhs >= rhs);
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         alpha_ff <= alpha;
      end
      if (ctl.en2) begin
         nsum_ff <= nsum_in;
      end
   end

endmodule

// File: src/bodlm_merge.sv
// Merge stage: combines the lane hits with the used bits into the result
// mask and its population count, held in the output register. Depends on bodlm_pkg.
`timescale 1ns / 1ps

module bodlm_merge
   import bodlm_pkg::*;
(
   input  logic                  clock,
   input  pipe_ctl_type          ctl,
   input  logic [MAX_LAYERS-1:0] hit,
   input  logic [3:0]            used,
   output rsp_payload_type       rsp_data
);

   rsp_payload_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.selected_mask  = hit & used;
      rsp_in.selected_count = 3'd0;
      for (int k = 0; k < MAX_LAYERS; k++) begin
         rsp_in.selected_count = rsp_in.selected_count + 3'(rsp_in.selected_mask[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: src/bilinear_ordered_dither_layer_mask.sv
// Top level of the bilinear ordered-dither layer mask: pipeline control,
// grid size register, front end, layer lanes and merge. Depends on bodlm_pkg.
//
//   channel   ports                            direction   payload
//   request   req_valid / req_ready / req_data in          req_payload_type
//   response  rsp_valid / rsp_ready / rsp_data out         rsp_payload_type
//   csr       csr_we / csr_wdata               in          grid_size, 8 bits
//
// Three register stages: a result passes the stage 1 and stage 2 registers and the
// output register before it reaches the response port, and one transaction is
// taken every cycle while the response side keeps up.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled response only holds the stages that are full behind it.
// Reset empties the pipeline and sets grid_size to 10; there is no clearing pass.
`timescale 1ns / 1ps

module bilinear_ordered_dither_layer_mask
   import bodlm_pkg::*;
#(
   parameter int LAYERS = LAYERS_DEF
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  logic [7:0]      csr_wdata
);

   logic [7:0]       grid_size_ff, grid_size_in;
   logic             v1_ff, v1_in;
   logic             v2_ff, v2_in;
   logic             v3_ff, v3_in;
   pipe_ctl_type     ctl;
   weights_type      weights;
   logic [15:0]      s2;
   logic [CMP_W-1:0] rhs;
   logic [3:0]       used;
   logic [15:0]      alpha [MAX_LAYERS];
   logic [MAX_LAYERS-1:0] hit;

   always_comb begin
      ctl.en3 = !v3_ff || rsp_ready;
      ctl.en2 = !v2_ff || ctl.en3;
      ctl.en1 = !v1_ff || ctl.en2;
      v1_in = ctl.en1 ? req_valid : v1_ff;
      v2_in = ctl.en2 ? v1_ff : v2_ff;
      v3_in = ctl.en3 ? v2_ff : v3_ff;
      grid_size_in = csr_we ? csr_wdata : grid_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         grid_size_ff <= GRID_SIZE_RESET;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         grid_size_ff <= grid_size_in;
      end
   end

   assign req_ready = ctl.en1;
   assign rsp_valid = v3_ff;

   assign alpha[0] = req_data.layer0_alpha;
   assign alpha[1] = req_data.layer1_alpha;
   assign alpha[2] = req_data.layer2_alpha;
   assign alpha[3] = req_data.layer3_alpha;

   bodlm_prep u_prep (
      .clock     (clock),
      .ctl       (ctl),
      .grid_size (grid_size_ff),
      .req_data  (req_data),
      .weights   (weights),
      .s2_out    (s2),
      .rhs_out   (rhs),
      .used_out  (used)
   );

   for (genvar k = 0; k < MAX_LAYERS; k++) begin : g_lane
      if (k < LAYERS) begin : g_on
         bodlm_lane u_lane (
            .clock   (clock),
            .ctl     (ctl),
            .alpha   (alpha[k]),
            .weights (weights),
            .s2      (s2),
            .rhs     (rhs),
            .hit     (hit[k])
         );
      end else begin : g_off
         assign hit[k] = 1'b0;
      end
   end

   bodlm_merge u_merge (
      .clock    (clock),
      .ctl      (ctl),
      .hit      (hit),
      .used     (used),
      .rsp_data (rsp_data)
   );

endmodule

// File: src/bodlm_checker.sv
// Port-level checks for the bilinear ordered-dither layer mask and the bind
// that attaches them to the top level. Depends on bodlm_pkg.
`timescale 1ns / 1ps

module bodlm_checker
   import bodlm_pkg::*;
#(
   parameter int LAYERS = LAYERS_DEF
)
(
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // The count always agrees with the mask it travels with.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.selected_count == 3'($countones(rsp_data.selected_mask)))
      else $error("selected_count does not match selected_mask");

   // Lanes beyond the configured layer count never report a hit.
   a_lanes_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (4'(rsp_data.selected_mask) >> LAYERS) == 4'd0)
      else $error("mask bit set above the configured layer count");

   // With no response pending the pipeline can always take a transaction.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked while no response is pending");

   // Reset leaves no response behind.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds its payload.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind bilinear_ordered_dither_layer_mask bodlm_checker #(.LAYERS(LAYERS)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: verif/bilinear_ordered_dither_layer_mask_tb.sv
// Self-checking testbench for the bilinear ordered-dither layer mask.
// Drives a directed table and then random grid points with random idling, takes
// typed masks from the table, predicts the rest internally, and needs bodlm_pkg and the top level.
`timescale 1ns / 1ps

module bilinear_ordered_dither_layer_mask_tb;
   import bodlm_pkg::*;

   localparam int CLK_HALF        = 6;
   localparam int RESET_CYCLES    = 2;
   localparam int POINTS_PER_PASS = 150;
   localparam int GRID_PASSES     = 7;
   localparam int STALL_AT_POINT  = 350;
   localparam int STALL_CYCLES    = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Magic square that seeds both levels of the dither pattern.
   localparam logic [3:0] BAYER_SEED [4][4] = '{
      '{4'd0,  4'd14, 4'd3,  4'd13},
      '{4'd11, 4'd5,  4'd8,  4'd6},
      '{4'd12, 4'd2,  4'd15, 4'd1},
      '{4'd7,  4'd9,  4'd4,  4'd10}
   };

   typedef struct packed {
      logic [7:0]  grid;
      logic [7:0]  x;
      logic [7:0]  z;
      logic [3:0]  sx;
      logic [3:0]  sz;
      logic [15:0] a0;
      logic [15:0] a1;
      logic [15:0] a2;
      logic [15:0] a3;
      logic [3:0]  used;
      logic        typed;
      logic [3:0]  mask;
      logic [2:0]  count;
   } point_row_type;

   localparam int DIRECTED_ROWS = 18;
   localparam point_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'd10,  8'h00, 8'h00, 4'h0, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        4'hF, 1'b1, 4'h0, 3'd0},
      '{8'd10,  8'h00, 8'h00, 4'h0, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        4'hF, 1'b1, 4'hF, 3'd4},
      // Layers not in use stay clear even at full density.
      '{8'd10,  8'h00, 8'h00, 4'h0, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        4'h0, 1'b1, 4'h0, 3'd0},
      '{8'd10,  8'h00, 8'h00, 4'h0, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        4'h5, 1'b1, 4'h5, 3'd2},
      // Column 10, row 10 holds the highest threshold of the pattern.
      '{8'd10,  8'h00, 8'h00, 4'hA, 4'hA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        4'hF, 1'b1, 4'hF, 3'd4},
      '{8'd10,  8'h00, 8'h00, 4'hA, 4'hA, 16'hEEEE, 16'hEEEE, 16'hEEEE, 16'hEEEE,
        4'hF, 1'b1, 4'h0, 3'd0},
      // Coordinates past the grid saturate to its last step.
      '{8'd10,  8'hFF, 8'hFF, 4'h3, 4'h7, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
        4'hF, 1'b0, 4'h0, 3'd0},
      '{8'd10,  8'h09, 8'h09, 4'h0, 4'h0, 16'hF000, 16'hF000, 16'hF000, 16'hF000,
        4'hF, 1'b0, 4'h0, 3'd0},
      '{8'd10,  8'h05, 8'h05, 4'h0, 4'h0, 16'h000F, 16'h00F0, 16'h0F00, 16'hF000,
        4'hF, 1'b0, 4'h0, 3'd0},
      '{8'd10,  8'h09, 8'h00, 4'hF, 4'hF, 16'h0F0F, 16'hF0F0, 16'hFF00, 16'h00FF,
        4'hA, 1'b0, 4'h0, 3'd0},
      '{8'd1,   8'h00, 8'h00, 4'h5, 4'h9, 16'h8888, 16'h7777, 16'hFFFF, 16'h0000,
        4'hF, 1'b0, 4'h0, 3'd0},
      '{8'd1,   8'hFF, 8'hFF, 4'hC, 4'h3, 16'hFFFF, 16'h1111, 16'hEEEE, 16'h8080,
        4'hF, 1'b0, 4'h0, 3'd0},
      // A grid size of zero behaves as a single step.
      '{8'd0,   8'hC8, 8'h03, 4'h0, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        4'hF, 1'b1, 4'hF, 3'd4},
      '{8'd0,   8'h00, 8'h80, 4'h6, 4'h2, 16'hA5A5, 16'h5A5A, 16'hC3C3, 16'h3C3C,
        4'hF, 1'b0, 4'h0, 3'd0},
      '{8'd255, 8'hFE, 8'hFE, 4'h0, 4'h0, 16'hF000, 16'h0F00, 16'h00F0, 16'h000F,
        4'hF, 1'b0, 4'h0, 3'd0},
      '{8'd255, 8'hFF, 8'hFF, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        4'hF, 1'b0, 4'h0, 3'd0},
      '{8'd255, 8'h00, 8'h80, 4'h1, 4'h8, 16'h7F3C, 16'h0123, 16'hFEDC, 16'h8421,
        4'h6, 1'b0, 4'h0, 3'd0},
      '{8'd255, 8'h80, 8'h00, 4'h8, 4'h1, 16'h1248, 16'h8421, 16'hF0F0, 16'h0F0F,
        4'h9, 1'b0, 4'h0, 3'd0}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_we = 1'b0;
   logic [7:0]      csr_wdata = '0;

   rsp_payload_type pending_masks [$];
   logic [7:0]      grid_now = GRID_SIZE_RESET;
   int              points_sent = 0;
   int              errors = 0;
   int              idle_cycles = 0;
   logic            quiet = 1'b0;
   logic            stall_req = 1'b0;
   logic            stall_over = 1'b0;

   bilinear_ordered_dither_layer_mask i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // Threshold of the two-level pattern, rescaled from 0..255 onto 0..253.
   function automatic int unsigned dither_level(input logic [3:0] col, input logic [3:0] row);
      int unsigned v;
      v = 16 * BAYER_SEED[col[1:0]][row[1:0]] + BAYER_SEED[col[3:2]][row[3:2]];
      return (64 + 127 * v) / 128;
   endfunction

   function automatic rsp_payload_type predict_mask(input req_payload_type p,
                                                    input logic [7:0] g);
      logic [7:0]      s;
      logic [7:0]      x;
      logic [7:0]      z;
      logic [3:0]      col;
      logic [3:0]      row;
      logic [15:0]     alpha [4];
      logic [31:0]     ix;
      logic [31:0]     iz;
      logic [31:0]     s2;
      logic [31:0]     num;
      logic [31:0]     thr;
      rsp_payload_type r;
      s = (g == 8'd0) ? 8'd1 : g;
      x = (p.grid_x > s - 8'd1) ? s - 8'd1 : p.grid_x;
      z = (p.grid_z > s - 8'd1) ? s - 8'd1 : p.grid_z;
      col = x[3:0] + p.shift_x;
      row = z[3:0] + p.shift_z;
      thr = 32'(dither_level(col, row));
      alpha = '{p.layer0_alpha, p.layer1_alpha, p.layer2_alpha, p.layer3_alpha};
      ix = 32'(s) - 32'(x);
      iz = 32'(s) - 32'(z);
      s2 = 32'(s) * 32'(s);
      r = '0;
      for (int k = 0; k < MAX_LAYERS; k++) begin
         num = 32'd17 * (32'(alpha[k][3:0]) * ix * iz + 32'(alpha[k][7:4]) * 32'(x) * iz
                        + 32'(alpha[k][11:8]) * ix * 32'(z)
                        + 32'(alpha[k][15:12]) * 32'(x) * 32'(z));
         // Rounded density beats the threshold: 2*num + s^2 >= 2*(thr+1)*s^2.
         if (p.layer_used[k] && (2 * num + s2 >= 2 * (thr + 1) * s2)) begin
            r.selected_mask[k] = 1'b1;
            r.selected_count   = r.selected_count + 3'd1;
         end
      end
      return r;
   endfunction

   function automatic req_payload_type random_point();
      req_payload_type p;
      logic [7:0]      s;
      logic [15:0]     a [4];
      s = (grid_now == 8'd0) ? 8'd1 : grid_now;
      // Mostly points inside the grid, with some that may saturate.
      p.grid_x = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, s - 1));
      p.grid_z = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, s - 1));
      p.shift_x = 4'($urandom);
      p.shift_z = 4'($urandom);
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            a[k] = {4{4'($urandom)}};
         end else begin
            a[k] = 16'($urandom);
         end
      end
      p.layer0_alpha = a[0];
      p.layer1_alpha = a[1];
      p.layer2_alpha = a[2];
      p.layer3_alpha = a[3];
      p.layer_used   = 4'($urandom);
      return p;
   endfunction

   task automatic send_point(input req_payload_type p, input logic typed,
                             input rsp_payload_type typed_rsp);
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed) begin
         pending_masks.push_back(typed_rsp);
      end else begin
         pending_masks.push_back(predict_mask(p, grid_now));
      end
      points_sent++;
      // No gaps from the sender in the last pass or while the response side is in its long hold-off.
      if (!quiet && !(stall_req && !stall_over) && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // The register only changes once the pipeline has drained.
   task automatic set_grid(input logic [7:0] g);
      req_valid <= 1'b0;
      while (pending_masks.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= g;
      @(posedge clock);
      csr_we   <= 1'b0;
      grid_now  = g;
   endtask

   initial begin
      req_payload_type p;
      rsp_payload_type t;
      logic [7:0]      pass_grid [GRID_PASSES];
      pass_grid = '{8'd255, 8'd1, 8'd0, 8'd2, 8'd16, 8'($urandom_range(3, 254)), 8'd10};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].grid != grid_now) set_grid(DIRECTED[i].grid);
         p.grid_x       = DIRECTED[i].x;
         p.grid_z       = DIRECTED[i].z;
         p.shift_x      = DIRECTED[i].sx;
         p.shift_z      = DIRECTED[i].sz;
         p.layer0_alpha = DIRECTED[i].a0;
         p.layer1_alpha = DIRECTED[i].a1;
         p.layer2_alpha = DIRECTED[i].a2;
         p.layer3_alpha = DIRECTED[i].a3;
         p.layer_used   = DIRECTED[i].used;
         t.selected_mask  = DIRECTED[i].mask;
         t.selected_count = DIRECTED[i].count;
         send_point(p, DIRECTED[i].typed, t);
      end

      for (int pass = 0; pass < GRID_PASSES; pass++) begin
         set_grid(pass_grid[pass]);
         if (pass == GRID_PASSES - 1) quiet = 1'b1;
         for (int n = 0; n < POINTS_PER_PASS; n++) begin
            if (points_sent == STALL_AT_POINT) stall_req = 1'b1;
            send_point(random_point(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_masks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Response side: random ready pattern, one long hold-off, steady at the end.
   initial begin
      @(negedge reset);
      forever begin
         if (stall_req && !stall_over) begin
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            stall_over = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_response
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_masks.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, mask %h count %0d",
                     $time, rsp_data.selected_mask, rsp_data.selected_count);
         end else begin
            want = pending_masks.pop_front();
            if (rsp_data.selected_mask !== want.selected_mask) begin
               errors++;
               $display("%0t: selected_mask expected %h actual %h",
                        $time, want.selected_mask, rsp_data.selected_mask);
            end
            if (rsp_data.selected_count !== want.selected_count) begin
               errors++;
               $display("%0t: selected_count expected %0d actual %0d",
                        $time, want.selected_count, rsp_data.selected_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
